@@ design/stt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

	// Sizes
	localparam int OFFSET_BITS   = 24;
	localparam int KEYWORD_COUNT = 6;
	localparam int FIELD_W       = 24;
	localparam int LINE_W        = 24;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	typedef logic [OFFSET_BITS-1:0] pos_t;
	typedef logic [LINE_W-1:0]      line_t;
	typedef logic [KEYWORD_COUNT-1:0] kw_bits_t;

	localparam pos_t  POS_MAX  = '1;
	localparam line_t LINE_MAX = '1;

	// Token kinds
	typedef enum logic [4:0] {
		KIND_IDENT   = 5'd0,
		KIND_KEYWORD = 5'd1,
		KIND_NUMBER  = 5'd2,
		KIND_STRING  = 5'd3,
		KIND_LPAREN  = 5'd4,
		KIND_RPAREN  = 5'd5,
		KIND_LBRACE  = 5'd6,
		KIND_RBRACE  = 5'd7,
		KIND_SEMI    = 5'd8,
		KIND_ASSIGN  = 5'd9,
		KIND_MINUS   = 5'd10,
		KIND_PLUS    = 5'd11,
		KIND_SLASH   = 5'd12,
		KIND_STAR    = 5'd13,
		KIND_LT      = 5'd14,
		KIND_LE      = 5'd15,
		KIND_GT      = 5'd16,
		KIND_GE      = 5'd17,
		KIND_COMMA   = 5'd18,
		KIND_LBRACK  = 5'd19,
		KIND_RBRACK  = 5'd20,
		KIND_EQEQ    = 5'd21,
		KIND_NE      = 5'd22,
		KIND_ANDAND  = 5'd23,
		KIND_OROR    = 5'd24,
		KIND_END     = 5'd25
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_UNEXPECTED = 2'd1,
		ERR_UNTERM_STR = 2'd2
	} err_t;

	// Pending token modes
	typedef enum logic [3:0] {
		MODE_IDLE    = 4'd0,
		MODE_IDENT   = 4'd1,
		MODE_NUM     = 4'd2,
		MODE_NEG     = 4'd3,
		MODE_SLASH   = 4'd4,
		MODE_COMMENT = 4'd5,
		MODE_STR     = 4'd6,
		MODE_LT      = 4'd7,
		MODE_GT      = 4'd8,
		MODE_EQ      = 4'd9,
		MODE_AMP     = 4'd10,
		MODE_BAR     = 4'd11,
		MODE_BANG    = 4'd12
	} mode_t;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	// Keyword spelling, first character in element 0, zero padded
	localparam logic [0:6][7:0] KW_TEXT [KEYWORD_COUNT] = '{
		{"if", 40'h0},
		{"else", 24'h0},
		{"while", 16'h0},
		{"for", 32'h0},
		{"return", 8'h0},
		{"null", 24'h0}
	};
	localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4};

	typedef struct packed {
		kind_t                kind;
		err_t                 err;
		logic [LINE_W-1:0]    line;
		logic [FIELD_W-1:0]   start;
		logic [FIELD_W-1:0]   len;
		logic                 last;
	} result_t;

	// Results of one input transaction: one or two
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} pair_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Single-byte symbols; KIND_IDENT means no symbol
	function automatic kind_t single_kind(logic [7:0] c);
		kind_t k;
		unique case (c)
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h7B:   k = KIND_LBRACE;
			8'h7D:   k = KIND_RBRACE;
			8'h3B:   k = KIND_SEMI;
			8'h2B:   k = KIND_PLUS;
			8'h2A:   k = KIND_STAR;
			8'h2C:   k = KIND_COMMA;
			8'h5B:   k = KIND_LBRACK;
			8'h5D:   k = KIND_RBRACK;
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

	// Drop keywords whose character at idx differs from c
	function automatic kw_bits_t kw_update(kw_bits_t bits, logic [2:0] idx, logic [7:0] c);
		kw_bits_t r;
		r = bits;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (idx == 3'd7)
				r[k] = 1'b0;
			else if (KW_TEXT[k][idx] != c)
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic kw_hit(kw_bits_t bits, logic [2:0] len);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (bits[k] && KW_LEN[k] != 3'd0 && KW_LEN[k] == len)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic result_t mk_res(kind_t k, err_t e, line_t ln, pos_t st, pos_t len);
		result_t r;
		r.kind  = k;
		r.err   = e;
		r.line  = ln;
		r.start = FIELD_W'(st);
		r.len   = FIELD_W'(len);
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/stt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stt_front import stt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic [7:0] char_code,
	input  wire logic  end_of_text,
	input  wire logic  queue_full,
	output logic       push,
	output pair_t      push_data
);

	mode_t    mode_q, mode_n;
	line_t    line_q, line_n;
	pos_t     pos_q, pos_n;
	pos_t     tstart_q, tstart_n;
	kw_bits_t kwbits_q, kwbits_n;
	logic [2:0] idlen_q, idlen_n;
	logic     halted_q, halted_n;

	logic     acc;
	pos_t     span, str_start, str_len;
	logic     cls_v;
	result_t  cls_r;
	logic     a_v, b_v, consumed;
	result_t  a_r, b_r;
	kind_t    sk;
	logic [7:0] want;

	assign in_ready = !queue_full;
	assign acc = in_valid && in_ready;

	// Token extents from the pending start
	always_comb begin
		span = (pos_q > tstart_q) ? pos_q - tstart_q : '0;
		str_len = (pos_q > tstart_q) ? pos_q - tstart_q - 1'b1 : '0;
		str_start = (tstart_q < POS_MAX) ? tstart_q + 1'b1 : tstart_q;
	end

	// Token that ends when the pending mode is closed
	always_comb begin
		cls_v = 1'b1;
		cls_r = mk_res(KIND_IDENT, ERR_NONE, line_q, tstart_q, pos_t'(1));
		unique case (mode_q) inside
			MODE_IDENT: cls_r = mk_res(kw_hit(kwbits_q, idlen_q) ? KIND_KEYWORD : KIND_IDENT,
				ERR_NONE, line_q, tstart_q, span);
			MODE_NUM:   cls_r = mk_res(KIND_NUMBER, ERR_NONE, line_q, tstart_q, span);
			MODE_NEG:   cls_r.kind = KIND_MINUS;
			MODE_SLASH: cls_r.kind = KIND_SLASH;
			MODE_LT:    cls_r.kind = KIND_LT;
			MODE_GT:    cls_r.kind = KIND_GT;
			MODE_EQ:    cls_r.kind = KIND_ASSIGN;
			MODE_STR:   cls_r = mk_res(KIND_IDENT, ERR_UNTERM_STR, line_q, tstart_q, '0);
			MODE_AMP, MODE_BAR, MODE_BANG:
				cls_r = mk_res(KIND_IDENT, ERR_UNEXPECTED, line_q, tstart_q, '0);
			default:    cls_v = 1'b0;
		endcase
	end

	// Per-byte decision: feed the pending token, then start a new one
	always_comb begin
		mode_n   = mode_q;
		line_n   = line_q;
		pos_n    = pos_q;
		tstart_n = tstart_q;
		kwbits_n = kwbits_q;
		idlen_n  = idlen_q;
		halted_n = halted_q;
		a_v      = 1'b0;
		a_r      = cls_r;
		b_v      = 1'b0;
		b_r      = mk_res(KIND_END, ERR_NONE, line_q, pos_q, '0);
		consumed = 1'b0;
		sk       = single_kind(char_code);
		want     = CH_AMP;

		if (end_of_text) begin
			a_v      = cls_v && !halted_q;
			b_v      = 1'b1;
			mode_n   = MODE_IDLE;
			line_n   = line_t'(1);
			pos_n    = '0;
			tstart_n = '0;
			kwbits_n = '1;
			idlen_n  = '0;
			halted_n = 1'b0;
		end else if (!halted_q) begin
			unique case (mode_q) inside
				MODE_IDLE: consumed = 1'b0;
				MODE_IDENT: begin
					if (is_alpha(char_code) || is_digit(char_code)) begin
						kwbits_n = kw_update(kwbits_q, idlen_q, char_code);
						idlen_n  = (idlen_q == 3'd7) ? idlen_q : idlen_q + 1'b1;
						consumed = 1'b1;
					end else begin
						a_v    = 1'b1;
						mode_n = MODE_IDLE;
					end
				end
				MODE_NUM: begin
					if (is_digit(char_code)) begin
						consumed = 1'b1;
					end else begin
						a_v    = 1'b1;
						mode_n = MODE_IDLE;
					end
				end
				MODE_NEG: begin
					if (is_digit(char_code)) begin
						mode_n   = MODE_NUM;
						consumed = 1'b1;
					end else begin
						a_v    = 1'b1;
						mode_n = MODE_IDLE;
					end
				end
				MODE_SLASH: begin
					if (char_code == CH_SLASH) begin
						mode_n   = MODE_COMMENT;
						consumed = 1'b1;
					end else begin
						a_v    = 1'b1;
						mode_n = MODE_IDLE;
					end
				end
				MODE_COMMENT: begin
					if (char_code != CH_NL)
						consumed = 1'b1;
					else
						mode_n = MODE_IDLE;
				end
				MODE_STR: begin
					consumed = 1'b1;
					if (char_code == CH_QUOTE) begin
						a_v    = 1'b1;
						a_r    = mk_res(KIND_STRING, ERR_NONE, line_q, str_start, str_len);
						mode_n = MODE_IDLE;
					end
				end
				MODE_LT, MODE_GT, MODE_EQ: begin
					if (char_code == CH_EQ) begin
						a_v      = 1'b1;
						a_r      = mk_res(mode_q == MODE_LT ? KIND_LE :
							(mode_q == MODE_GT ? KIND_GE : KIND_EQEQ),
							ERR_NONE, line_q, tstart_q, pos_t'(2));
						consumed = 1'b1;
					end else begin
						a_v = 1'b1;
					end
					mode_n = MODE_IDLE;
				end
				MODE_AMP, MODE_BAR, MODE_BANG: begin
					want = (mode_q == MODE_AMP) ? CH_AMP : ((mode_q == MODE_BAR) ? CH_BAR : CH_EQ);
					a_v  = 1'b1;
					if (char_code == want) begin
						a_r = mk_res(mode_q == MODE_AMP ? KIND_ANDAND :
							(mode_q == MODE_BAR ? KIND_OROR : KIND_NE),
							ERR_NONE, line_q, tstart_q, pos_t'(2));
					end else begin
						halted_n = 1'b1;
					end
					consumed = 1'b1;
					mode_n   = MODE_IDLE;
				end
				default: mode_n = MODE_IDLE;
			endcase

			// Start a new token with this byte
			if (!consumed) begin
				tstart_n = pos_q;
				b_r      = mk_res(sk, ERR_NONE, line_q, pos_q, pos_t'(1));
				if (char_code == CH_SPACE || char_code == CH_TAB) begin
					b_v = 1'b0;
				end else if (char_code == CH_NL) begin
					line_n = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
				end else if (is_alpha(char_code)) begin
					mode_n   = MODE_IDENT;
					kwbits_n = kw_update('1, 3'd0, char_code);
					idlen_n  = 3'd1;
				end else if (is_digit(char_code)) begin
					mode_n = MODE_NUM;
				end else if (char_code == CH_SLASH) begin
					mode_n = MODE_SLASH;
				end else if (char_code == CH_MINUS) begin
					mode_n = MODE_NEG;
				end else if (char_code == CH_QUOTE) begin
					mode_n = MODE_STR;
				end else if (char_code == CH_LT) begin
					mode_n = MODE_LT;
				end else if (char_code == CH_GT) begin
					mode_n = MODE_GT;
				end else if (char_code == CH_EQ) begin
					mode_n = MODE_EQ;
				end else if (char_code == CH_AMP) begin
					mode_n = MODE_AMP;
				end else if (char_code == CH_BAR) begin
					mode_n = MODE_BAR;
				end else if (char_code == CH_BANG) begin
					mode_n = MODE_BANG;
				end else if (sk != KIND_IDENT) begin
					b_v = 1'b1;
				end else begin
					b_v      = 1'b1;
					b_r      = mk_res(KIND_IDENT, ERR_UNEXPECTED, line_q, pos_q, '0);
					halted_n = 1'b1;
				end
			end

			pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		end
	end

	// Pack the results of this transaction, last flag on the final one
	always_comb begin
		push_data.two = a_v && b_v;
		push_data.r0  = a_v ? a_r : b_r;
		push_data.r1  = b_r;
		push_data.r0.last = !(a_v && b_v);
		push_data.r1.last = 1'b1;
		push = acc && (a_v || b_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			line_q   <= line_t'(1);
			pos_q    <= '0;
			tstart_q <= '0;
			kwbits_q <= '1;
			idlen_q  <= '0;
			halted_q <= 1'b0;
		end else if (acc) begin
			mode_q   <= mode_n;
			line_q   <= line_n;
			pos_q    <= pos_n;
			tstart_q <= tstart_n;
			kwbits_q <= kwbits_n;
			idlen_q  <= idlen_n;
			halted_q <= halted_n;
		end
	end

endmodule

`default_nettype wire

@@ design/stt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stt_queue import stt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire pair_t push_data,
	output logic       full,
	input  wire logic  pop,
	output logic       q_valid,
	output pair_t      q_data
);

	pair_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/stt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stt_back import stt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire pair_t q_data,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    cur
);

	pair_t hold_q;
	logic  valid_q, phase_q;
	logic  finish, load;

	// Retire the held pair after its final transaction
	assign finish = valid_q && out_ready && (phase_q || !hold_q.two);
	assign load   = !valid_q || finish;
	assign pop    = load && q_valid;

	assign out_valid = valid_q;
	assign cur       = phase_q ? hold_q.r1 : hold_q.r0;

	always_ff @(posedge clk) begin
		if (pop)
			hold_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (finish) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (valid_q && out_ready) begin
			phase_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ design/source_text_tokenizer_top.sv @@
// Source text tokenizer.
// Input channel (in_valid/in_ready): one byte of text per transaction in
// char_code, or end_of_text set to close the text. Output channel
// (out_valid/out_ready): one token per transaction with kind, error code,
// line, start offset and length; last marks the final token of an input byte.
// An input byte causes zero, one or two tokens.
// Throughput: one input byte per cycle while the queue is not full. The lexer
// state updates in the cycle a byte is accepted, so bytes may follow back to
// back. The output side delivers one token per cycle while out_ready is high;
// a byte that causes two tokens uses one output transaction per token,
// absorbed by a four-entry queue of per-byte token groups. The accepting edge
// writes a byte's tokens into the queue; the output register loads them from there.
// Stall: when out_ready is low the token holds; once the queue is full,
// in_ready drops until the receiver takes tokens again.
// Reset: arst_n clears the lexer to line 1, offset 0, no pending token, and
// empties the queue and output register. An end_of_text transaction returns
// the lexer to the same state after emitting the end marker.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer_top import stt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       token_kind,
	output logic [1:0]       error_code,
	output logic [23:0]      line_number,
	output logic [23:0]      start_offset,
	output logic [23:0]      value_length,
	output logic             last
);

	logic    queue_full, push, pop, q_valid;
	pair_t   push_data, q_data;
	result_t cur;

	stt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	stt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (queue_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	stt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cur      (cur)
	);

	// Drive the token fields
	assign token_kind   = cur.kind;
	assign error_code   = cur.err;
	assign line_number  = cur.line;
	assign start_offset = cur.start;
	assign value_length = cur.len;
	assign last         = cur.last;

endmodule

`default_nettype wire
